// ----- design/button_debounce_click_longpress_defines.svh -----
// Assertion macros for the button debounce block
`ifndef BUTTON_DEBOUNCE_CLICK_LONGPRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_LONGPRESS_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define BDC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("bdc assertion failed");

`define BDC_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("bdc forbidden condition seen");

`else

`define BDC_ASSERT(label, prop)

`define BDC_NEVER(label, expr)

`endif

`endif

// ----- design/btn_dbc_pkg.sv -----
`default_nettype none

package btn_dbc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int TIME_EXT_W    = 64;
    localparam int NOW_W         = 32;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 2'd1;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TIME_RST   = 16'd30;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_TIME_RST = 16'd600;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_REINIT = 1'b1;

endpackage

`default_nettype wire

// ----- design/button_debounce_click_longpress.sv -----
// Channel  | valid        | flow control | payload
// ---------+--------------+--------------+-----------------------------------------------
// sample   | i_valid      | o_stall      | i_action, i_raw_down, i_now_ms
// result   | o_valid      | i_stall      | o_level_down, o_*_event, o_hold_time
// config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One sample per clock while o_stall is low; its result appears in the output register on the next cycle.
// The state update is two time subtractions and compares, done in the accepting cycle.
// o_stall is high only while a result is held and the result side stalls.
// A re-initialise transaction updates the state and leaves no result.
// Reset (i_rst_n low, synchronous) clears the state and loads register defaults.
`default_nettype none
`include "button_debounce_click_longpress_defines.svh"

module button_debounce_click_longpress
    import btn_dbc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_action,
    input  wire logic                  i_raw_down,
    input  wire logic [NOW_W-1:0]      i_now_ms,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_level_down,
    output logic                       o_press_event,
    output logic                       o_release_event,
    output logic                       o_click_event,
    output logic                       o_long_press_event,
    output logic [NOW_W-1:0]           o_hold_time,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_debounce_time;
    logic [CFG_DATA_W-1:0] r_long_press_time;

    logic                 r_raw_level;
    logic [TIME_BITS-1:0] r_raw_change_time;
    logic                 r_stable_level;
    logic                 r_long_done;
    logic [TIME_BITS-1:0] r_press_time;

    logic                 r_out_valid;
    logic                 r_level_down;
    logic                 r_press_event;
    logic                 r_release_event;
    logic                 r_click_event;
    logic                 r_long_press_event;
    logic [NOW_W-1:0]     r_hold_time;

    logic                 accept;
    logic                 out_taken;
    logic [TIME_EXT_W-1:0] now_ext;
    logic [TIME_BITS-1:0] now_t;

    logic                 n_raw_level;
    logic [TIME_BITS-1:0] n_raw_change_time;
    logic [TIME_BITS-1:0] since_change;
    logic                 deb_ok;
    logic                 n_stable_level;
    logic                 press;
    logic                 release_ev;
    logic                 click;
    logic [TIME_BITS-1:0] n_press_time;
    logic                 long_done_mid;
    logic [TIME_BITS-1:0] hold;
    logic                 long_press;
    logic                 n_long_done;
    logic [TIME_EXT_W-1:0] hold_ext;

    assign o_cfg_ready = 1'b1;

    assign out_taken = r_out_valid && !i_stall;
    assign o_stall   = r_out_valid && i_stall;
    assign accept    = i_valid && !o_stall;

    assign now_ext = {{(TIME_EXT_W-NOW_W){1'b0}}, i_now_ms};
    assign now_t   = now_ext[TIME_BITS-1:0];

    always_comb begin
        n_raw_level       = r_raw_level;
        n_raw_change_time = r_raw_change_time;
        if (i_raw_down != r_raw_level) begin
            n_raw_level       = i_raw_down;
            n_raw_change_time = now_t;
        end

        since_change = now_t - n_raw_change_time;
        deb_ok = (since_change >= TIME_BITS'(r_debounce_time))
                 && (r_stable_level != n_raw_level);

        n_stable_level = deb_ok ? n_raw_level : r_stable_level;
        press          = deb_ok && n_raw_level;
        release_ev     = deb_ok && !n_raw_level;
        click          = release_ev && !r_long_done;
        n_press_time   = press ? now_t : r_press_time;
        long_done_mid  = press ? 1'b0 : r_long_done;

        hold       = n_stable_level ? (now_t - n_press_time) : '0;
        long_press = n_stable_level && !long_done_mid
                     && (hold >= TIME_BITS'(r_long_press_time));
        n_long_done = long_done_mid || long_press;
        hold_ext    = TIME_EXT_W'(hold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time   <= DEBOUNCE_TIME_RST;
            r_long_press_time <= LONG_PRESS_TIME_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DEBOUNCE_TIME:   r_debounce_time   <= i_cfg_data;
                REG_LONG_PRESS_TIME: r_long_press_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_level       <= 1'b0;
            r_raw_change_time <= '0;
            r_stable_level    <= 1'b0;
            r_long_done       <= 1'b0;
            r_press_time      <= '0;
        end else if (accept) begin
            if (i_action == ACT_REINIT) begin
                r_raw_level       <= i_raw_down;
                r_stable_level    <= i_raw_down;
                r_long_done       <= 1'b0;
                r_raw_change_time <= now_t;
                r_press_time      <= now_t;
            end else begin
                r_raw_level       <= n_raw_level;
                r_raw_change_time <= n_raw_change_time;
                r_stable_level    <= n_stable_level;
                r_long_done       <= n_long_done;
                r_press_time      <= n_press_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_action == ACT_SAMPLE) begin
            r_out_valid <= 1'b1;
        end else if (out_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_action == ACT_SAMPLE) begin
            r_level_down       <= n_stable_level;
            r_press_event      <= press;
            r_release_event    <= release_ev;
            r_click_event      <= click;
            r_long_press_event <= long_press;
            r_hold_time        <= hold_ext[NOW_W-1:0];
        end
    end

    assign o_valid            = r_out_valid;
    assign o_level_down       = r_level_down;
    assign o_press_event      = r_press_event;
    assign o_release_event    = r_release_event;
    assign o_click_event      = r_click_event;
    assign o_long_press_event = r_long_press_event;
    assign o_hold_time        = r_hold_time;

    `BDC_ASSERT(a_click_needs_release, o_valid && o_click_event |-> o_release_event)
    `BDC_ASSERT(a_released_hold_zero, o_valid && !o_level_down |-> o_hold_time == '0)
    `BDC_ASSERT(a_long_press_held, o_valid && o_long_press_event |-> o_level_down)
    `BDC_NEVER(a_press_and_release, o_valid && o_press_event && o_release_event)
    `BDC_ASSERT(a_reinit_no_result,
        !o_stall && i_valid && i_action == ACT_REINIT && !r_out_valid |=> !o_valid)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import btn_dbc_pkg::*;

    typedef struct packed {
        logic             level_down;
        logic             press_event;
        logic             release_event;
        logic             click_event;
        logic             long_press_event;
        logic [NOW_W-1:0] hold_time;
    } t_button_result;

    localparam int IDLE_LIMIT = 4000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_action = ACT_SAMPLE;
    logic                  i_raw_down = 1'b0;
    logic [NOW_W-1:0]      i_now_ms = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_level_down;
    logic                  o_press_event;
    logic                  o_release_event;
    logic                  o_click_event;
    logic                  o_long_press_event;
    logic [NOW_W-1:0]      o_hold_time;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    button_debounce_click_longpress dut (.*);

    // button model state
    logic [CFG_DATA_W-1:0] mdl_debounce;
    logic [CFG_DATA_W-1:0] mdl_long_press;
    logic                  mdl_raw;
    logic [NOW_W-1:0]      mdl_raw_change;
    logic                  mdl_stable;
    logic                  mdl_long_done;
    logic [NOW_W-1:0]      mdl_press_at;

    t_button_result expected_results[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;
    logic [NOW_W-1:0] clock_ms = '0;
    logic [CFG_DATA_W-1:0] cur_debounce;
    logic [CFG_DATA_W-1:0] cur_long_press;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void predict_button(input logic act, input logic raw,
                                           input logic [NOW_W-1:0] now);
        t_button_result r;
        logic [NOW_W-1:0] elapsed;
        r = '0;
        if (act == ACT_REINIT) begin
            mdl_raw = raw;
            mdl_stable = raw;
            mdl_long_done = 1'b0;
            mdl_raw_change = now;
            mdl_press_at = now;
            return;
        end
        if (raw != mdl_raw) begin
            mdl_raw = raw;
            mdl_raw_change = now;
        end
        elapsed = now - mdl_raw_change;
        if (elapsed >= {16'd0, mdl_debounce} && mdl_stable != mdl_raw) begin
            mdl_stable = mdl_raw;
            if (mdl_stable) begin
                r.press_event = 1'b1;
                mdl_press_at = now;
                mdl_long_done = 1'b0;
            end else begin
                r.release_event = 1'b1;
                r.click_event = !mdl_long_done;
            end
        end
        if (mdl_stable) begin
            r.hold_time = now - mdl_press_at;
            if (!mdl_long_done && r.hold_time >= {16'd0, mdl_long_press}) begin
                mdl_long_done = 1'b1;
                r.long_press_event = 1'b1;
            end
        end
        r.level_down = mdl_stable;
        expected_results.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        t_button_result want;
        t_button_result got;
        logic moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                got = {o_level_down, o_press_event, o_release_event, o_click_event,
                       o_long_press_event, o_hold_time};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: lvl=%b prs=%b rel=%b clk=%b lp=%b hold=%0d",
                                 got.level_down, got.press_event, got.release_event,
                                 got.click_event, got.long_press_event, got.hold_time);
                end else begin
                    want = expected_results.pop_front();
                    if (got.level_down !== want.level_down ||
                        got.press_event !== want.press_event ||
                        got.release_event !== want.release_event ||
                        got.click_event !== want.click_event ||
                        got.long_press_event !== want.long_press_event ||
                        got.hold_time !== want.hold_time) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected lvl=%b prs=%b rel=%b clk=%b lp=%b hold=%0d",
                                     want.level_down, want.press_event, want.release_event,
                                     want.click_event, want.long_press_event, want.hold_time);
                            $display("          got      lvl=%b prs=%b rel=%b clk=%b lp=%b hold=%0d",
                                     got.level_down, got.press_event, got.release_event,
                                     got.click_event, got.long_press_event, got.hold_time);
                        end
                    end
                end
            end
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                predict_button(i_action, i_raw_down, i_now_ms);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    REG_DEBOUNCE_TIME:   mdl_debounce = i_cfg_data;
                    REG_LONG_PRESS_TIME: mdl_long_press = i_cfg_data;
                    default: ;
                endcase
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= stall_tick[1];
        endcase
    end

    task automatic drive_sample(input logic act, input logic raw, input logic [NOW_W-1:0] now);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_action <= act;
        i_raw_down <= raw;
        i_now_ms <= now;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0 || o_valid) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index == REG_DEBOUNCE_TIME)
            cur_debounce = data;
        else if (index == REG_LONG_PRESS_TIME)
            cur_long_press = data;
    endtask

    task automatic write_times(input logic [CFG_DATA_W-1:0] debounce,
                               input logic [CFG_DATA_W-1:0] long_press);
        write_reg(REG_DEBOUNCE_TIME, debounce);
        write_reg(REG_LONG_PRESS_TIME, long_press);
    endtask

    task automatic test_reset_defaults();
        drive_sample(ACT_SAMPLE, 1'b1, 32'd0);
        drive_sample(ACT_SAMPLE, 1'b1, 32'd30);
        drive_sample(ACT_SAMPLE, 1'b1, 32'd629);
        drive_sample(ACT_SAMPLE, 1'b1, 32'd630);
        drive_sample(ACT_SAMPLE, 1'b0, 32'd700);
        drive_sample(ACT_SAMPLE, 1'b0, 32'd730);
    endtask

    task automatic test_corner_cases();
        write_reg(REG_DEBOUNCE_TIME, 16'd0);
        write_reg(REG_LONG_PRESS_TIME, 16'hFFFF);
        write_reg(2'd2, 16'h5A5A);
        write_reg(2'd3, 16'hA5A5);
        drive_sample(ACT_REINIT, 1'b0, 32'hFFFF_FFF0);
        drive_sample(ACT_SAMPLE, 1'b1, 32'hFFFF_FFF8);
        drive_sample(ACT_SAMPLE, 1'b1, 32'h0000_0005);
        drive_sample(ACT_SAMPLE, 1'b0, 32'h0000_0010);
        drive_sample(ACT_SAMPLE, 1'b0, 32'hFFFF_FFFF);
        write_reg(REG_LONG_PRESS_TIME, 16'd0);
        drive_sample(ACT_SAMPLE, 1'b1, 32'd0);
        drive_sample(ACT_SAMPLE, 1'b1, 32'd1);
        drive_sample(ACT_SAMPLE, 1'b0, 32'd2);
        drive_sample(ACT_REINIT, 1'b1, 32'hFFFF_FFFF);
        drive_sample(ACT_SAMPLE, 1'b1, 32'd0);
        drive_sample(ACT_SAMPLE, 1'b0, 32'd1);
        write_reg(REG_DEBOUNCE_TIME, 16'hFFFF);
        write_reg(REG_LONG_PRESS_TIME, 16'hFFFF);
        drive_sample(ACT_REINIT, 1'b0, 32'd0);
        drive_sample(ACT_SAMPLE, 1'b1, 32'd1);
        drive_sample(ACT_SAMPLE, 1'b1, 32'h0001_0000);
        drive_sample(ACT_SAMPLE, 1'b1, 32'h0001_FFFE);
        drive_sample(ACT_SAMPLE, 1'b1, 32'h0001_FFFF);
        drive_sample(ACT_SAMPLE, 1'b0, 32'h0002_0000);
        drive_sample(ACT_SAMPLE, 1'b1, 32'h0002_0001);
        drive_sample(ACT_SAMPLE, 1'b0, 32'h0003_0001);
        drive_sample(ACT_SAMPLE, 1'b0, 32'h0004_0000);
    endtask

    task automatic test_random_press_sequences();
        int s;
        int k;
        int span;
        int sent;
        logic level;
        logic raw;
        logic [NOW_W-1:0] step;
        for (s = 0; s < 8; s++) begin
            case (s)
                0: write_times(16'd30, 16'd600);
                1: write_times(16'd0, 16'd0);
                2: write_times(16'hFFFF, 16'hFFFF);
                3: write_times(16'd0, 16'hFFFF);
                4: write_times(16'hFFFF, 16'd0);
                5: write_times(16'd5, 16'd40);
                default: write_times(CFG_DATA_W'($urandom_range(1, 80)),
                                     CFG_DATA_W'($urandom_range(1, 400)));
            endcase
            case ($urandom_range(0, 2))
                0: clock_ms = $urandom;
                1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
                default: ;
            endcase
            drive_sample(ACT_REINIT, 1'b0, clock_ms);
            level = 1'b0;
            sent = 0;
            while (sent < 130) begin
                level = !level;
                span = $urandom_range(2, 12);
                for (k = 0; k < span; k++) begin
                    raw = level;
                    if (k < 2 && $urandom_range(0, 4) == 0)
                        raw = !level;
                    case ($urandom_range(0, 5))
                        0: step = $urandom_range(0, 2);
                        1: step = cur_debounce / 2;
                        2: step = NOW_W'(cur_debounce);
                        3: step = cur_debounce + $urandom_range(0, 3);
                        4: step = cur_long_press / 3 + $urandom_range(0, 2);
                        default: step = $urandom_range(0, 1000);
                    endcase
                    clock_ms = clock_ms + step;
                    drive_sample(ACT_SAMPLE, raw, clock_ms);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random_noise();
        int n;
        logic act;
        write_reg(REG_DEBOUNCE_TIME, CFG_DATA_W'($urandom_range(0, 20)));
        write_reg(REG_LONG_PRESS_TIME, CFG_DATA_W'($urandom_range(0, 100)));
        for (n = 0; n < 250; n++) begin
            if (n == 125) begin
                write_reg(REG_DEBOUNCE_TIME, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(REG_LONG_PRESS_TIME, CFG_DATA_W'($urandom_range(0, 65535)));
            end
            act = ($urandom_range(0, 7) == 0) ? ACT_REINIT : ACT_SAMPLE;
            if ($urandom_range(0, 4) == 0)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, 40);
            drive_sample(act, 1'($urandom_range(0, 1)), clock_ms);
        end
    endtask

    initial begin
        mdl_debounce = DEBOUNCE_TIME_RST;
        mdl_long_press = LONG_PRESS_TIME_RST;
        cur_debounce = DEBOUNCE_TIME_RST;
        cur_long_press = LONG_PRESS_TIME_RST;
        mdl_raw = 1'b0;
        mdl_raw_change = '0;
        mdl_stable = 1'b0;
        mdl_long_done = 1'b0;
        mdl_press_at = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_corner_cases();
        test_random_press_sequences();
        test_random_noise();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/btn_dbc_pkg.sv
design/button_debounce_click_longpress.sv
tb/testbench.sv
